@@ rtl/bfr_pkg.sv @@
// shared types, font rom and glyph selection for the bitmap font rect generator
package bfr_pkg;

	localparam int GLYPH_H = 5;
	localparam int GLYPH_W = 5;
	localparam int CELLS = GLYPH_H * GLYPH_W;
	localparam logic [11:0] PEN_MAX = 12'd4095;

	typedef logic [5:0] glyph_idx_t;

	localparam glyph_idx_t GLYPH_DOT = 6'd36;
	localparam glyph_idx_t GLYPH_COLON = 6'd37;
	localparam glyph_idx_t GLYPH_SPACE = 6'd38;
	localparam glyph_idx_t GLYPH_PERCENT = 6'd39;
	localparam glyph_idx_t GLYPH_LETTER_BASE = 6'd10;

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_rows_t;
	typedef logic [CELLS-1:0] cell_mask_t;

	typedef struct packed {
		logic [2:0]  width;
		glyph_rows_t rows;
	} glyph_t;

	// one queued character: lit cells in row-major order from bit 0
	typedef struct packed {
		cell_mask_t  mask;
		logic [11:0] pen;
		logic [11:0] row;
		logic [3:0]  size;
	} job_t;

	function automatic glyph_idx_t select_glyph(input logic [7:0] c);
		logic [7:0] folded;
		logic [7:0] ofs;
		begin
			folded = c & ~CASE_BIT;
			ofs = folded - CH_UPPER_A + 8'(GLYPH_LETTER_BASE);
			if (c == CH_DOT) begin
				select_glyph = GLYPH_DOT;
			end else if (c == CH_COLON) begin
				select_glyph = GLYPH_COLON;
			end else if (c == CH_PERCENT) begin
				select_glyph = GLYPH_PERCENT;
			end else if (c[7] == 1'b0 && folded >= CH_UPPER_A && folded <= CH_UPPER_Z) begin
				select_glyph = ofs[5:0];
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				select_glyph = 6'(c - CH_ZERO);
			end else begin
				select_glyph = GLYPH_SPACE;
			end
		end
	endfunction

	function automatic glyph_t font_rom(input glyph_idx_t idx);
		begin
			case (idx)
				6'd0:  font_rom = {3'd4, 5'd12, 5'd18, 5'd18, 5'd18, 5'd12};
				6'd1:  font_rom = {3'd3, 5'd8,  5'd24, 5'd8,  5'd8,  5'd28};
				6'd2:  font_rom = {3'd4, 5'd12, 5'd18, 5'd4,  5'd8,  5'd30};
				6'd3:  font_rom = {3'd4, 5'd28, 5'd2,  5'd12, 5'd2,  5'd28};
				6'd4:  font_rom = {3'd4, 5'd6,  5'd10, 5'd18, 5'd30, 5'd2};
				6'd5:  font_rom = {3'd4, 5'd30, 5'd16, 5'd30, 5'd2,  5'd28};
				6'd6:  font_rom = {3'd4, 5'd12, 5'd16, 5'd28, 5'd18, 5'd12};
				6'd7:  font_rom = {3'd4, 5'd30, 5'd2,  5'd4,  5'd4,  5'd4};
				6'd8:  font_rom = {3'd4, 5'd12, 5'd18, 5'd12, 5'd18, 5'd12};
				6'd9:  font_rom = {3'd4, 5'd12, 5'd18, 5'd14, 5'd2,  5'd12};
				6'd10: font_rom = {3'd4, 5'd12, 5'd18, 5'd30, 5'd18, 5'd18};
				6'd11: font_rom = {3'd4, 5'd28, 5'd18, 5'd28, 5'd18, 5'd28};
				6'd12: font_rom = {3'd4, 5'd14, 5'd16, 5'd16, 5'd16, 5'd14};
				6'd13: font_rom = {3'd4, 5'd28, 5'd18, 5'd18, 5'd18, 5'd28};
				6'd14: font_rom = {3'd4, 5'd30, 5'd16, 5'd28, 5'd16, 5'd30};
				6'd15: font_rom = {3'd4, 5'd30, 5'd16, 5'd28, 5'd16, 5'd16};
				6'd16: font_rom = {3'd4, 5'd14, 5'd16, 5'd22, 5'd18, 5'd14};
				6'd17: font_rom = {3'd4, 5'd18, 5'd18, 5'd30, 5'd18, 5'd18};
				6'd18: font_rom = {3'd1, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16};
				6'd19: font_rom = {3'd4, 5'd2,  5'd2,  5'd2,  5'd18, 5'd12};
				6'd20: font_rom = {3'd4, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18};
				6'd21: font_rom = {3'd3, 5'd16, 5'd16, 5'd16, 5'd16, 5'd28};
				6'd22: font_rom = {3'd5, 5'd17, 5'd27, 5'd21, 5'd17, 5'd17};
				6'd23: font_rom = {3'd4, 5'd18, 5'd26, 5'd22, 5'd18, 5'd18};
				6'd24: font_rom = {3'd4, 5'd12, 5'd18, 5'd18, 5'd18, 5'd12};
				6'd25: font_rom = {3'd4, 5'd28, 5'd18, 5'd28, 5'd16, 5'd16};
				6'd26: font_rom = {3'd5, 5'd12, 5'd18, 5'd22, 5'd18, 5'd13};
				6'd27: font_rom = {3'd4, 5'd28, 5'd18, 5'd28, 5'd20, 5'd18};
				6'd28: font_rom = {3'd4, 5'd14, 5'd16, 5'd12, 5'd2,  5'd28};
				6'd29: font_rom = {3'd5, 5'd31, 5'd4,  5'd4,  5'd4,  5'd4};
				6'd30: font_rom = {3'd4, 5'd18, 5'd18, 5'd18, 5'd18, 5'd12};
				6'd31: font_rom = {3'd5, 5'd17, 5'd17, 5'd10, 5'd10, 5'd4};
				6'd32: font_rom = {3'd5, 5'd21, 5'd21, 5'd21, 5'd10, 5'd10};
				6'd33: font_rom = {3'd4, 5'd18, 5'd18, 5'd12, 5'd18, 5'd18};
				6'd34: font_rom = {3'd5, 5'd17, 5'd17, 5'd14, 5'd4,  5'd4};
				6'd35: font_rom = {3'd4, 5'd30, 5'd2,  5'd12, 5'd16, 5'd30};
				6'd36: font_rom = {3'd1, 5'd0,  5'd0,  5'd0,  5'd0,  5'd16};
				6'd37: font_rom = {3'd1, 5'd0,  5'd16, 5'd0,  5'd16, 5'd0};
				6'd39: font_rom = {3'd5, 5'd17, 5'd2,  5'd4,  5'd8,  5'd17};
				default: font_rom = {3'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
			endcase
		end
	endfunction

	// row y, column x lands on bit y*5+x, so the lowest set bit is the next cell to draw
	function automatic cell_mask_t glyph_mask(input glyph_t g);
		cell_mask_t m;
		begin
			m = '0;
			for (int y = 0; y < GLYPH_H; y++) begin
				for (int x = 0; x < GLYPH_W; x++) begin
					m[y*GLYPH_W+x] = g.rows[y][GLYPH_W-1-x] && (3'(x) < g.width);
				end
			end
			glyph_mask = m;
		end
	endfunction

endpackage

@@ rtl/bfr_in_if.sv @@
// character input channel
interface bfr_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  char_code;
	logic        string_start;
	logic [11:0] start_col;
	logic [11:0] text_row;
	logic [3:0]  cell_size;

	modport source(output valid, output char_code, output string_start, output start_col,
		output text_row, output cell_size, input ready);
	modport sink(input valid, input char_code, input string_start, input start_col,
		input text_row, input cell_size, output ready);
endinterface

@@ rtl/bfr_out_if.sv @@
// rectangle output channel
interface bfr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] left;
	logic [15:0] top;
	logic [15:0] right;
	logic [15:0] bottom;
	logic        last_rect;

	modport source(output valid, output left, output top, output right, output bottom,
		output last_rect, input ready);
	modport sink(input valid, input left, input top, input right, input bottom,
		input last_rect, output ready);
endinterface

@@ rtl/bitmap_font_rect_generator_unit.sv @@
// A character's first rectangle passes through the job queue, the back end's job registers
// and the output register. The back end emits one rectangle per cycle while the output is
// ready, one per lit cell (1 to 13), set by the single cell walker; blank glyphs give none.
// The job queue (QUEUE_DEPTH entries) lets the front keep taking characters until full.
// Reset clears the pen column to 0 and empties the queue and the output register.
module bitmap_font_rect_generator_unit import bfr_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	bfr_in_if.sink    char_in,
	bfr_out_if.source rect_out
);

	logic push;
	logic push_ready;
	job_t push_job;
	logic pop;
	logic pop_valid;
	job_t pop_job;

	bfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.push       (push),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	bfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	bfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.pop       (pop),
		.rect_out  (rect_out)
	);

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("back end popped an empty queue");

	a_push_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (char_in.valid && char_in.ready))
		else $error("job pushed without an input beat");

	a_rect_square: assert property (@(posedge clk) disable iff (!arst_n)
		rect_out.valid |->
			(16'(rect_out.right - rect_out.left) == 16'(rect_out.bottom - rect_out.top)))
		else $error("rectangle is not one cell square");

endmodule

@@ rtl/bfr_front.sv @@
// front end: glyph lookup, pen tracking and job issue
module bfr_front import bfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bfr_in_if.sink       char_in,
	output logic         push,
	input  logic         push_ready,
	output job_t         push_job
);

	logic        accept;
	logic [11:0] pen_q;
	logic [11:0] pen_cur;
	logic [12:0] pen_sum;
	glyph_t      glyph;

	assign char_in.ready = push_ready;
	assign accept = char_in.valid && push_ready;

	assign glyph = font_rom(select_glyph(char_in.char_code));
	assign pen_cur = char_in.string_start ? char_in.start_col : pen_q;
	assign pen_sum = 13'(pen_cur) + 13'(glyph.width) + 13'd1;

	assign push_job.mask = glyph_mask(glyph);
	assign push_job.pen = pen_cur;
	assign push_job.row = char_in.text_row;
	assign push_job.size = char_in.cell_size;

	// blank glyphs only move the pen
	assign push = accept && (push_job.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= '0;
		end else if (accept) begin
			pen_q <= pen_sum[12] ? PEN_MAX : pen_sum[11:0];
		end
	end

endmodule

@@ rtl/bfr_queue.sv @@
// small job fifo between front and back
module bfr_queue import bfr_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  job_t push_job,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		begin
			ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		end
	endfunction

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/bfr_back.sv @@
// back end: walks a glyph's lit cells; one rectangle per cycle when not stalled
module bfr_back import bfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  job_t     job,
	output logic     pop,
	bfr_out_if.source rect_out
);

	logic        active_q;
	cell_mask_t  mask_q;
	logic [11:0] pen_q;
	logic [11:0] row_q;
	logic [3:0]  size_q;

	logic        out_valid_q;
	logic [15:0] left_q;
	logic [15:0] top_q;
	logic [15:0] right_q;
	logic [15:0] bottom_q;
	logic        last_q;

	cell_mask_t  lowest;
	logic [2:0]  cx;
	logic [2:0]  cy;
	logic        last;
	logic        advance;
	logic [16:0] left_full;
	logic [16:0] top_full;

	assign lowest = mask_q & (~mask_q + CELLS'(1));
	assign last = ((mask_q & ~lowest) == '0);

	always_comb begin
		cx = '0;
		cy = '0;
		for (int y = 0; y < GLYPH_H; y++) begin
			for (int x = 0; x < GLYPH_W; x++) begin
				if (lowest[y*GLYPH_W+x]) begin
					cx = cx | 3'(x);
					cy = cy | 3'(y);
				end
			end
		end
	end

	assign left_full = (13'(pen_q) + 13'(cx)) * 4'(size_q);
	assign top_full = (13'(row_q) + 13'(cy)) * 4'(size_q);

	assign advance = active_q && (!out_valid_q || rect_out.ready);
	// take the next job in the cycle the current one finishes
	assign pop = job_valid && (!active_q || (advance && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (advance && last) begin
				active_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rect_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_q <= left_full[15:0];
			top_q <= top_full[15:0];
			right_q <= 16'(left_full + 17'(size_q));
			bottom_q <= 16'(top_full + 17'(size_q));
			last_q <= last;
		end
		if (pop) begin
			mask_q <= job.mask;
			pen_q <= job.pen;
			row_q <= job.row;
			size_q <= job.size;
		end else if (advance) begin
			mask_q <= mask_q & ~lowest;
		end
	end

	assign rect_out.valid = out_valid_q;
	assign rect_out.left = left_q;
	assign rect_out.top = top_q;
	assign rect_out.right = right_q;
	assign rect_out.bottom = bottom_q;
	assign rect_out.last_rect = last_q;

endmodule
